// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mailbox checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox check failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mailbox check failed");

`endif

// ===== hw/rtl/cemf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cemf_pkg
// Types and constants of the CAN emergency frame mailbox.
// ---------------------------------------------------------------------------
package cemf_pkg;

   localparam int NODE_BITS = 7;
   localparam int NODE_SLOTS = 128;
   // the bus port is one bit wide, so at most two buses can be addressed
   localparam int BUS_PORT_VALUES = 2;

   localparam logic [10:0] EMCY_BASE = 11'd128;
   localparam logic [10:0] EMCY_MAX_OFFSET = 11'd127;
   localparam logic [10:0] EMCY_LAST = EMCY_BASE + EMCY_MAX_OFFSET;
   localparam logic [3:0] MIN_LENGTH = 4'd3;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_TAKE  = 2'd1,
      KIND_PEEK  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        bus;
      logic [10:0] can_id;
      logic [3:0]  frame_length;
      logic [7:0]  code_low_byte;
      logic [7:0]  code_high_byte;
      logic [6:0]  node;
   } req_type;

   typedef struct packed {
      logic        pending;
      logic [15:0] code;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [15:0] code;
      logic [31:0] event_count;
   } rsp_type;

endpackage

// ===== hw/rtl/cemf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cemf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cemf_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cemf_clear.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cemf_clear
// Post-reset sweep that zeroes every mailbox entry, one per cycle.
// ---------------------------------------------------------------------------
module cemf_clear #(
   parameter int DEPTH = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   output logic              active,
   output logic [ADDR_W-1:0] addr
);

   logic              active_ff;
   logic [ADDR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else if (active_ff) begin
         addr_ff <= addr_ff + ADDR_W'(1);
         // stop after the last entry
         if (addr_ff == ADDR_W'(DEPTH - 1)) begin
            active_ff <= 1'b0;
         end
      end
   end

   assign active = active_ff;
   assign addr   = addr_ff;

endmodule

// ===== hw/rtl/cemf_exec.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cemf_exec
// Execute stage: decode the item, update entry and bus counter, register result.
// ---------------------------------------------------------------------------
module cemf_exec #(
   parameter int BUS_COUNT = 2,
   parameter int ADDR_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                stage_valid,
   input  cemf_pkg::req_type   stage_req,
   input  cemf_pkg::entry_type entry,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output cemf_pkg::entry_type wr_entry,
   output cemf_pkg::rsp_type   rsp
);
   import cemf_pkg::*;

   logic [31:0]          count_ff [BUS_PORT_VALUES];
   logic [31:0]          count_in [BUS_PORT_VALUES];
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 bus_ok;
   logic                 frame_ok;
   logic [NODE_BITS-1:0] slot_node;

   always_comb begin
      bus_ok   = ({31'd0, stage_req.bus} < 32'(BUS_COUNT));
      frame_ok = (stage_req.can_id > EMCY_BASE) && (stage_req.can_id <= EMCY_LAST) &&
                 (stage_req.frame_length >= MIN_LENGTH);
      // a frame addresses node (id - base), which is the low id bits in range
      slot_node = (stage_req.kind == KIND_FRAME) ? stage_req.can_id[NODE_BITS-1:0]
                                                 : stage_req.node;
      wr_addr = ADDR_W'({stage_req.bus, slot_node});

      count_in        = count_ff;
      wr_en           = 1'b0;
      wr_entry        = entry;
      rsp_in.valid    = stage_valid;
      rsp_in.ok       = 1'b0;
      rsp_in.code     = 16'd0;

      if (stage_valid && bus_ok) begin
         unique case (kind_type'(stage_req.kind))
            KIND_FRAME: begin
               if (frame_ok) begin
                  wr_en                    = 1'b1;
                  wr_entry.pending         = 1'b1;
                  wr_entry.code            = {stage_req.code_high_byte,
                                              stage_req.code_low_byte};
                  count_in[stage_req.bus]  = count_ff[stage_req.bus] + 32'd1;
                  rsp_in.ok                = 1'b1;
               end
            end
            KIND_TAKE: begin
               if (entry.pending) begin
                  wr_en            = 1'b1;
                  wr_entry.pending = 1'b0;
                  rsp_in.ok        = 1'b1;
                  rsp_in.code      = entry.code;
               end
            end
            KIND_PEEK: begin
               rsp_in.ok   = 1'b1;
               rsp_in.code = entry.code;
            end
            default: begin
            end
         endcase
      end

      rsp_in.event_count = bus_ok ? count_in[stage_req.bus] : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0]  <= 32'd0;
         count_ff[1]  <= 32'd0;
         rsp_ff.valid <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== hw/rtl/can_emergency_frame_mailbox_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// can_emergency_frame_mailbox_unit
// Per-bus, per-node cache of CAN emergency frames with pending marks and
// per-bus accepted frame counters.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive start with the req_ fields; the transfer happens at
//   a rising edge where start is high and busy is low. req_kind selects the
//   operation: store a received frame, take a pending event, or peek.
//   Result channel: rsp_valid is high for exactly one cycle per item, with
//   rsp_ok, rsp_code and rsp_event_count; the receiver cannot stall it.
//   Pipeline: the entry read register loads at the transfer edge beside the
//   input register, and the execute stage then loads the result register,
//   which drives rsp_valid and the other result fields.
//   Throughput: one item per cycle while busy is low; per item one entry RAM
//   read and at most one write, with a bypass for back-to-back same-entry items.
//   Reset: synchronous. Counters and control clear at once, then a sweep
//   zeroes the entry RAM, one entry per cycle, BUS_USED*128 entries (BUS_COUNT
//   capped at two buses, 256 entries at the default). busy stays high during
//   reset and the sweep.
// ---------------------------------------------------------------------------
module can_emergency_frame_mailbox_unit #(
   parameter int BUS_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic        req_bus,
   input  logic [10:0] req_can_id,
   input  logic [3:0]  req_frame_length,
   input  logic [7:0]  req_code_low_byte,
   input  logic [7:0]  req_code_high_byte,
   input  logic [6:0]  req_node,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [15:0] rsp_code,
   output logic [31:0] rsp_event_count
);
   import cemf_pkg::*;

   // buses beyond what the bus port can address get no storage
   localparam int BUS_USED = (BUS_COUNT < BUS_PORT_VALUES) ? BUS_COUNT : BUS_PORT_VALUES;
   localparam int DEPTH    = BUS_USED * NODE_SLOTS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ENTRY_W  = $bits(entry_type);

   logic                 accept;
   req_type              req_word;
   logic [NODE_BITS-1:0] rd_node;
   logic [ADDR_W-1:0]    rd_addr;

   logic                 stage_valid_ff;
   req_type              stage_req_ff;

   logic [ENTRY_W-1:0]   ram_q;
   logic                 byp_hit_ff;
   entry_type            byp_entry_ff;
   entry_type            entry_sel;

   logic                 exec_wr_en;
   logic [ADDR_W-1:0]    exec_wr_addr;
   entry_type            exec_wr_entry;
   rsp_type              rsp;

   logic                 clear_active;
   logic [ADDR_W-1:0]    clear_addr;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;

   // hold off transfers during reset and the clearing sweep
   assign busy   = clear_active || reset;
   assign accept = start && !busy;

   assign req_word = '{kind:           req_kind,
                       bus:            req_bus,
                       can_id:         req_can_id,
                       frame_length:   req_frame_length,
                       code_low_byte:  req_code_low_byte,
                       code_high_byte: req_code_high_byte,
                       node:           req_node};

   // address the entry that this item will touch; frames use the id's node
   assign rd_node = (req_kind == KIND_FRAME) ? req_can_id[NODE_BITS-1:0] : req_node;
   assign rd_addr = ADDR_W'({req_bus, rd_node});

   // input register: capture the transfer alongside the RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
      if (accept) begin
         stage_req_ff <= req_word;
      end
   end

   // forward the execute-stage write when the next item reads the same entry
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else begin
         byp_hit_ff <= exec_wr_en && (exec_wr_addr == rd_addr);
      end
      byp_entry_ff <= exec_wr_entry;
   end

   assign entry_sel = byp_hit_ff ? byp_entry_ff : entry_type'(ram_q);

   // sweep owns the write port until it finishes; no items run meanwhile
   assign ram_wr_en   = clear_active || exec_wr_en;
   assign ram_wr_addr = clear_active ? clear_addr : exec_wr_addr;
   assign ram_wr_data = clear_active ? '0 : ENTRY_W'(exec_wr_entry);

   cemf_clear #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_clear (
      .clock  (clock),
      .reset  (reset),
      .active (clear_active),
      .addr   (clear_addr)
   );

   cemf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   cemf_exec #(
      .BUS_COUNT (BUS_COUNT),
      .ADDR_W    (ADDR_W)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage_req   (stage_req_ff),
      .entry       (entry_sel),
      .wr_en       (exec_wr_en),
      .wr_addr     (exec_wr_addr),
      .wr_entry    (exec_wr_entry),
      .rsp         (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_ok          = rsp.ok;
   assign rsp_code        = rsp.code;
   assign rsp_event_count = rsp.event_count;

endmodule

// ===== hw/rtl/cemf_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// cemf_checker
// Port-level timing and result checks for the emergency frame mailbox.
// ---------------------------------------------------------------------------
module cemf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_kind,
   input logic        req_bus,
   input logic [3:0]  req_frame_length,
   input logic        rsp_valid,
   input logic        rsp_ok
);
   import cemf_pkg::*;

   // every result traces back to an earlier transfer
   `ASSERT_IMPLY(a_rsp_has_cmd, clock, reset, rsp_valid, $past(start && !busy, 2))
   // and every transfer not cut by reset yields one
   `ASSERT_IMPLY(a_cmd_has_rsp, clock, reset, $past(start && !busy, 2) && !$past(reset), rsp_valid)
   // reset starts the clearing sweep
   `ASSERT_NEXT(a_reset_busy, clock, reset, busy)
   // a peek on bus zero always succeeds
   `ASSERT_IMPLY(a_peek_ok, clock, reset, rsp_valid && $past(start && !busy && req_kind == KIND_PEEK && req_bus == 1'b0, 2), rsp_ok)
   // a frame that is too short is refused
   `ASSERT_IMPLY(a_short_frame, clock, reset, rsp_valid && $past(start && !busy && req_kind == KIND_FRAME && req_frame_length < MIN_LENGTH, 2), !rsp_ok)

endmodule

bind can_emergency_frame_mailbox_unit cemf_checker u_checker (.*);
